>>> rtl/drcr_pkg.sv
// shared types and constants for the read completion reorder unit
// used by drcr_ctrl, drcr_datapath and dram_read_completion_reorder_core
package drcr_pkg;

    localparam int unsigned PENDING_DEPTH = 32;
    localparam int unsigned EARLY_DEPTH   = 32;
    localparam int unsigned ADDR_BITS     = 32;
    localparam int unsigned DATA_BITS     = 64;

    localparam int unsigned PEND_IW  = $clog2(PENDING_DEPTH);
    localparam int unsigned PEND_CW  = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned EARLY_CW = $clog2(EARLY_DEPTH + 1);

    localparam logic FUNC_ISSUE = 1'b0;
    localparam logic FUNC_CPL   = 1'b1;

    typedef enum logic [1:0] {
        STS_RESP       = 2'd0,
        STS_NO_PEND    = 2'd1,
        STS_EARLY_FULL = 2'd2,
        STS_PEND_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic        func;
        logic [31:0] dram_addr;
        logic [15:0] resp_tag;
        logic        burst_last;
        logic [63:0] read_data;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_tag;
        logic [63:0] out_data;
        logic        out_burst_last;
        logic        run_last;
    } t_res;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          tag;
        logic                 last;
    } t_pend;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    push;
        logic    park;
        logic    pop;
        logic    hold_item;
        logic    hold_early;
        logic    match_cap;
        logic    emit_status;
        t_status status;
        logic    emit_hold;
        logic    run_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_issue;
        logic pend_full;
        logic pend_empty;
        logic head_match;
        logic early_full;
        logic early_empty;
        logic found;
    } t_sts;

endpackage

>>> rtl/drcr_ctrl.sv
// sequencing state machine for the read completion reorder unit
// depends on drcr_pkg; drives drcr_datapath through t_cmd, reads t_sts
module drcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  drcr_pkg::t_sts i_sts,
    output drcr_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_SEL  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = drcr_pkg::STS_RESP;
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                priority if (i_sts.is_issue) begin
                    if (i_sts.pend_full) begin
                        o_cmd.emit_status = 1'b1;
                        o_cmd.status      = drcr_pkg::STS_PEND_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_sts.pend_empty) begin
                    o_cmd.emit_status = 1'b1;
                    o_cmd.status      = drcr_pkg::STS_NO_PEND;
                end else if (!i_sts.head_match) begin
                    if (i_sts.early_full) begin
                        o_cmd.emit_status = 1'b1;
                        o_cmd.status      = drcr_pkg::STS_EARLY_FULL;
                    end else begin
                        o_cmd.park = 1'b1;
                    end
                end else begin
                    o_cmd.hold_item = 1'b1;
                    o_cmd.pop       = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                // new head is being read; stop if either store ran dry
                if (i_sts.pend_empty || i_sts.early_empty) begin
                    o_cmd.emit_hold = 1'b1;
                    o_cmd.run_last  = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.match_cap = 1'b1;
                n_state         = S_SEL;
            end
            S_SEL: begin
                o_cmd.emit_hold = 1'b1;
                if (i_sts.found) begin
                    o_cmd.hold_early = 1'b1;
                    o_cmd.pop        = 1'b1;
                    n_state          = S_RD;
                end else begin
                    o_cmd.run_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/drcr_datapath.sv
// pending queue memory, early buffer, match logic and result register
// depends on drcr_pkg; commanded by drcr_ctrl
module drcr_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  drcr_pkg::t_item i_item,
    input  drcr_pkg::t_cmd  i_cmd,
    output drcr_pkg::t_sts  o_sts,
    output drcr_pkg::t_res  o_res,
    output logic            o_res_vld
);

    localparam int unsigned IW  = drcr_pkg::PEND_IW;
    localparam int unsigned CW  = drcr_pkg::PEND_CW;
    localparam int unsigned ECW = drcr_pkg::EARLY_CW;
    localparam int unsigned ED  = drcr_pkg::EARLY_DEPTH;
    localparam int unsigned AB  = drcr_pkg::ADDR_BITS;
    localparam int unsigned DB  = drcr_pkg::DATA_BITS;

    drcr_pkg::t_item r_item;
    drcr_pkg::t_pend r_pend_mem [drcr_pkg::PENDING_DEPTH];
    drcr_pkg::t_pend r_head_rd;
    logic [IW-1:0]   r_head;
    logic [CW-1:0]   r_pend_cnt;

    logic [AB-1:0]   r_early_addr [ED];
    logic [DB-1:0]   r_early_data [ED];
    logic [ECW-1:0]  r_early_cnt;
    logic [ED-1:0]   r_match;

    logic [15:0]     r_hold_tag;
    logic [DB-1:0]   r_hold_data;
    logic            r_hold_last;

    drcr_pkg::t_res  r_res;
    logic            r_res_vld;

    logic [IW:0]     w_tail_sum;
    logic [IW-1:0]   w_tail;
    logic [IW-1:0]   w_head_inc;
    drcr_pkg::t_pend w_in_pend;
    logic [ED-1:0]   w_match;
    logic [ED-1:0]   w_first;
    logic [ED-1:0]   w_shift;
    logic [DB-1:0]   w_sel_data;

    // tail = head + count, wrapped once
    assign w_tail_sum = (IW + 1)'(r_head) + (IW + 1)'(r_pend_cnt);
    assign w_tail     = (w_tail_sum >= (IW + 1)'(drcr_pkg::PENDING_DEPTH))
                      ? IW'(w_tail_sum - (IW + 1)'(drcr_pkg::PENDING_DEPTH))
                      : IW'(w_tail_sum);
    assign w_head_inc = (r_head == IW'(drcr_pkg::PENDING_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign w_in_pend.addr = r_item.dram_addr[AB-1:0];
    assign w_in_pend.tag  = r_item.resp_tag;
    assign w_in_pend.last = r_item.burst_last;

    always_comb begin
        for (int j = 0; j < ED; j++) begin
            w_match[j] = (r_early_addr[j] == r_head_rd.addr) && (ECW'(j) < r_early_cnt);
        end
    end

    // oldest match as one-hot; entries at or above it shift down on removal
    assign w_first = r_match & (~r_match + 1'b1);
    assign w_shift = ~(w_first - 1'b1);

    always_comb begin
        w_sel_data = '0;
        for (int j = 0; j < ED; j++) begin
            w_sel_data = w_sel_data | (w_first[j] ? r_early_data[j] : '0);
        end
    end

    assign o_sts.is_issue    = (r_item.func == drcr_pkg::FUNC_ISSUE);
    assign o_sts.pend_full   = (r_pend_cnt == CW'(drcr_pkg::PENDING_DEPTH));
    assign o_sts.pend_empty  = (r_pend_cnt == '0);
    assign o_sts.head_match  = (r_head_rd.addr == r_item.dram_addr[AB-1:0]);
    assign o_sts.early_full  = (r_early_cnt == ECW'(ED));
    assign o_sts.early_empty = (r_early_cnt == '0);
    assign o_sts.found       = |r_match;

    // pending queue memory, head read registered every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_pend_mem[w_tail] <= w_in_pend;
        end
        r_head_rd <= r_pend_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.match_cap) begin
            r_match <= w_match;
        end
        if (i_cmd.hold_item) begin
            r_hold_tag  <= r_head_rd.tag;
            r_hold_last <= r_head_rd.last;
            r_hold_data <= r_item.read_data[DB-1:0];
        end else if (i_cmd.hold_early) begin
            r_hold_tag  <= r_head_rd.tag;
            r_hold_last <= r_head_rd.last;
            r_hold_data <= w_sel_data;
        end
    end

    // early buffer kept oldest first
    always_ff @(posedge i_clk) begin
        if (i_cmd.park) begin
            for (int j = 0; j < ED; j++) begin
                if (r_early_cnt == ECW'(j)) begin
                    r_early_addr[j] <= r_item.dram_addr[AB-1:0];
                    r_early_data[j] <= r_item.read_data[DB-1:0];
                end
            end
        end
        if (i_cmd.hold_early) begin
            for (int j = 0; j < ED - 1; j++) begin
                if (w_shift[j]) begin
                    r_early_addr[j] <= r_early_addr[j+1];
                    r_early_data[j] <= r_early_data[j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_pend_cnt  <= '0;
            r_early_cnt <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pend_cnt <= r_pend_cnt + 1'b1;
            end else if (i_cmd.pop) begin
                r_pend_cnt <= r_pend_cnt - 1'b1;
                r_head     <= w_head_inc;
            end
            if (i_cmd.park) begin
                r_early_cnt <= r_early_cnt + 1'b1;
            end else if (i_cmd.hold_early) begin
                r_early_cnt <= r_early_cnt - 1'b1;
            end
            r_res_vld <= i_cmd.emit_status | i_cmd.emit_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_res.status         <= i_cmd.status;
            r_res.out_tag        <= '0;
            r_res.out_data       <= '0;
            r_res.out_burst_last <= 1'b0;
            r_res.run_last       <= 1'b1;
        end else if (i_cmd.emit_hold) begin
            r_res.status         <= drcr_pkg::STS_RESP;
            r_res.out_tag        <= r_hold_tag;
            r_res.out_data       <= 64'(r_hold_data);
            r_res.out_burst_last <= r_hold_last;
            r_res.run_last       <= i_cmd.run_last;
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    a_pend_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= CW'(drcr_pkg::PENDING_DEPTH))
        else $error("pending count beyond depth");

    a_early_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_early_cnt <= ECW'(ED))
        else $error("early count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_pend_cnt != '0))
        else $error("pop from empty pending queue");

    a_take_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hold_early |-> ($onehot(w_first) && (r_early_cnt != '0)))
        else $error("early entry taken without a match");

    a_match_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.match_cap |=> ((r_match >> r_early_cnt) == '0))
        else $error("match bit above early count");

endmodule

>>> rtl/dram_read_completion_reorder_core.sv
// Read completion reorder unit for one memory channel: issued reads queue in
// order; a completion that matches the queue head is released as a response,
// followed by parked completions matching each new head, oldest first; other
// completions park in a 32-entry early buffer. An item is taken when start is
// high and busy is low. An issue, a parked completion or a status result is handled
// by capture, then a decision against the registered head of the pending queue
// memory. A completion that releases responses drains until a store runs dry or
// a new head has no parked match: each further release needs a memory read of the
// new head, a registered compare across the early buffer and a select-and-compact
// step, and the closing check costs one read or all three.
// Results come out of an output register in the cycle after they are decided,
// each on o_res for exactly one cycle with o_res_vld; the receiver cannot
// stall, so nothing here waits on it. run_last marks the last result of an item.
// depends on drcr_pkg, drcr_ctrl and drcr_datapath
module dram_read_completion_reorder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  drcr_pkg::t_item i_item,
    output drcr_pkg::t_res  o_res,
    output logic            o_res_vld
);

    drcr_pkg::t_cmd w_cmd;
    drcr_pkg::t_sts w_sts;

    drcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    drcr_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_res     (o_res),
        .o_res_vld (o_res_vld)
    );

endmodule
